>>> sv/psp_pkg.sv
package psp_pkg;

  localparam int unsigned QueueDepthDef = 32;
  localparam int unsigned MaxResults    = 32;
  localparam int unsigned UsPerMs       = 1000;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_BURST = 2'd1,
    FUNC_SEND  = 2'd2,
    FUNC_FLUSH = 2'd3
  } func_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [31:0]        now_us;
    logic [15:0]        packet_tag;
    logic [31:0]        stream_id;
    logic [7:0]         burst_count;
    logic [15:0]        spread_ms;
    logic               burst_last;
    logic signed [31:0] default_timeout_ms;
  } in_item_t;

  typedef struct packed {
    logic               send_valid;
    logic [15:0]        sent_tag;
    logic signed [31:0] timeout_ms;
    logic [5:0]         queue_count;
    logic               dropped_full;
    logic               last;
  } out_item_t;

  // queue entry as stored in the entry memory
  typedef struct packed {
    logic [31:0] due;
    logic [15:0] tag;
    logic [31:0] stream;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_HEAD_RD,
    ST_HEAD_WAIT,
    ST_TDIV,
    ST_EMIT,
    ST_EMIT_LAST
  } state_t;

endpackage

>>> sv/packet_send_pacer_top.sv
// Channel   Ports                         Direction  Handshake
// input     in_item                       in         start & !busy
// result    out_item                      out        out_strobe, one cycle
//
// Each queue entry walked is read, then written back if it stays.
// Tick or flush: a walk of the queue, then the timeout when entries
// remain, then the results. A queued burst element: a walk for insert,
// after a step divide at burst start. Reset clears the state, the queue
// count and the burst state only.
// Results cannot be stalled; busy stays high until the last one leaves.
module packet_send_pacer_top #(
  parameter int unsigned QUEUE_DEPTH = psp_pkg::QueueDepthDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  psp_pkg::in_item_t   in_item,
  output logic                out_strobe,
  output psp_pkg::out_item_t  out_item
);

  import psp_pkg::*;

  localparam int unsigned AddrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SentW = $clog2(MaxResults + 1);
  // ceil(2^38 / 1000): exact ms quotient for magnitudes up to 2^31
  localparam logic [28:0] MsRecip = 29'd274877907;

  state_t        state_r, state_nxt;
  in_item_t      it_r, it_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic [7:0]    bpos_r, bpos_nxt;
  logic [31:0]   bstart_r, bstart_nxt;
  logic [25:0]   bstep_r, bstep_nxt;
  logic [CntW-1:0] rd_i_r, rd_i_nxt;   // read index
  logic [CntW-1:0] wr_j_r, wr_j_nxt;   // write index (compaction / insert)
  logic          ins_done_r, ins_done_nxt;
  logic          drop_r, drop_nxt;
  logic          stop_r, stop_nxt;    // tick hit a not-due head or full sends; timeout phase
  entry_t        new_r, new_nxt;      // entry being inserted
  logic [SentW-1:0] nsent_r, nsent_nxt;
  logic [SentW-1:0] emit_r, emit_nxt;
  logic [15:0]   sent_q [MaxResults];
  logic          sent_we;
  logic [15:0]   sent_wd;
  logic signed [31:0] tmo_r, tmo_nxt;
  logic          tneg_r, tneg_nxt;
  logic [31:0]   tmag_r, tmag_nxt;    // |head - now| in us

  // entry memory
  logic          m_we;
  logic [AddrW-1:0] m_wa, m_ra;
  entry_t        m_wd, m_rd;

  psp_ram #(.Width(EntryW), .Depth(QUEUE_DEPTH)) u_mem (
    .clk    (clk),
    .wr_en  (m_we),
    .wr_addr(m_wa),
    .wr_data(m_wd),
    .rd_addr(m_ra),
    .rd_data(m_rd)
  );

  // divider for the burst step
  logic        d_go, d_done;
  logic [31:0] d_a, d_b, d_q;
  psp_div #(.Width(32)) u_div (
    .clk(clk), .rst_n(rst_n), .go(d_go), .dividend(d_a), .divisor(d_b),
    .done(d_done), .quotient(d_q)
  );

  logic [31:0] due_new;
  logic signed [31:0] diff_rd;
  logic [31:0] head_diff;
  logic [60:0] tprod;
  logic [31:0] tquo;
  logic        accept;
  logic        immediate;
  logic        matched;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign immediate = (it_r.burst_count < 8'd2) || (it_r.spread_ms == 16'd0);
  assign due_new   = bstart_r + 32'(bpos_r) * 32'(bstep_r);
  assign diff_rd   = $signed(m_rd.due - it_r.now_us);
  assign head_diff = m_rd.due - it_r.now_us;
  assign matched   = (m_rd.stream == it_r.stream_id) && (nsent_r < SentW'(MaxResults));
  assign tprod     = 61'(tmag_r) * 61'(MsRecip);
  assign tquo      = 32'(tprod[60:38]);

  // sent-tag buffer: written at the send-count index, read at the emit index
  always_ff @(posedge clk) begin
    if (sent_we) begin
      sent_q[nsent_r[$clog2(MaxResults)-1:0]] <= sent_wd;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    it_nxt       = it_r;
    count_nxt    = count_r;
    bpos_nxt     = bpos_r;
    bstart_nxt   = bstart_r;
    bstep_nxt    = bstep_r;
    rd_i_nxt     = rd_i_r;
    wr_j_nxt     = wr_j_r;
    ins_done_nxt = ins_done_r;
    drop_nxt     = drop_r;
    stop_nxt     = stop_r;
    new_nxt      = new_r;
    nsent_nxt    = nsent_r;
    emit_nxt     = emit_r;
    tmo_nxt      = tmo_r;
    tneg_nxt     = tneg_r;
    tmag_nxt     = tmag_r;
    sent_we      = 1'b0;
    sent_wd      = it_r.packet_tag;
    m_we         = 1'b0;
    m_wa         = wr_j_r[AddrW-1:0];
    m_wd         = m_rd;
    m_ra         = rd_i_r[AddrW-1:0];
    d_go         = 1'b0;
    d_a          = 32'(it_r.spread_ms) * 32'(UsPerMs);
    d_b          = 32'(it_r.burst_count);
    out_strobe   = 1'b0;
    out_item     = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          it_nxt     = in_item;
          rd_i_nxt   = '0;
          wr_j_nxt   = '0;
          drop_nxt   = 1'b0;
          stop_nxt   = 1'b0;
          nsent_nxt  = '0;
          emit_nxt   = '0;
          ins_done_nxt = 1'b0;
          m_ra       = '0;
          case (func_t'(in_item.func))
            FUNC_TICK, FUNC_FLUSH: state_nxt = ST_SCAN_WAIT;
            FUNC_SEND: state_nxt = ST_EMIT_LAST;
            FUNC_BURST: begin
              if (bpos_r == 8'd0) begin
                bstart_nxt = in_item.now_us;
                d_go       = 1'b1;
                d_a        = 32'(in_item.spread_ms) * 32'(UsPerMs);
                d_b        = 32'(in_item.burst_count);
                state_nxt  = ST_DIV;
              end else begin
                state_nxt  = ST_SCAN;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end

      // burst step divide
      ST_DIV: begin
        if (d_done) begin
          bstep_nxt = (it_r.burst_count >= 8'd2) ? d_q[25:0] : 26'd0;
          state_nxt = ST_SCAN;
        end
      end

      // set up the burst element, then send it, drop it when full, or walk for insert
      ST_SCAN: begin
        bpos_nxt = it_r.burst_last ? 8'd0 : bpos_r + 8'd1;
        if (immediate) begin
          state_nxt = ST_EMIT_LAST;
        end else if (count_r >= CntW'(QUEUE_DEPTH)) begin
          drop_nxt  = 1'b1;
          state_nxt = ST_HEAD_RD;
        end else begin
          new_nxt   = '{due: due_new, tag: it_r.packet_tag, stream: it_r.stream_id};
          rd_i_nxt  = '0;
          m_ra      = '0;
          state_nxt = ST_SCAN_WAIT;
        end
      end

      // walk step: m_rd holds entry rd_i_r; ST_HEAD_WAIT reads the next
      ST_SCAN_WAIT: begin
        state_nxt = ST_HEAD_RD;
        if (rd_i_r < count_r) begin
          state_nxt = ST_SCAN_WAIT;
          case (func_t'(it_r.func))
            FUNC_TICK: begin
              if (stop_r || diff_rd > 0 || nsent_r == SentW'(MaxResults)) begin
                stop_nxt = 1'b1;
                m_we = 1'b1;
              end else begin
                sent_we   = 1'b1;
                sent_wd   = m_rd.tag;
                nsent_nxt = nsent_r + 1'b1;
              end
            end
            FUNC_FLUSH: begin
              if (matched) begin
                sent_we   = 1'b1;
                sent_wd   = m_rd.tag;
                nsent_nxt = nsent_r + 1'b1;
              end else begin
                m_we = 1'b1;
              end
            end
            default: begin
              // insert: shift the tail up by one, writing from low to high
              m_we = 1'b1;
              if (!ins_done_r && $signed(m_rd.due - new_r.due) > 0) begin
                m_wd         = new_r;
                new_nxt      = m_rd;
                ins_done_nxt = 1'b1;
              end else if (ins_done_r) begin
                m_wd    = new_r;
                new_nxt = m_rd;
              end
            end
          endcase
          if (m_we) begin
            wr_j_nxt = wr_j_r + 1'b1;
          end
          rd_i_nxt = rd_i_r + 1'b1;
          m_ra     = AddrW'(rd_i_r + 1'b1);
          // hold the read address through ST_HEAD_WAIT so m_rd tracks rd_i
          state_nxt = ST_HEAD_WAIT;
        end else begin
          // end of walk
          if (func_t'(it_r.func) == FUNC_BURST) begin
            m_we      = 1'b1;
            m_wd      = new_r;
            count_nxt = count_r + 1'b1;
          end else begin
            count_nxt = wr_j_r;
          end
          state_nxt = ST_HEAD_RD;
        end
      end

      // read of the next entry of the walk
      ST_HEAD_WAIT: begin
        m_ra      = rd_i_r[AddrW-1:0];
        state_nxt = ST_SCAN_WAIT;
      end

      ST_HEAD_RD: begin
        m_ra = '0;
        if (count_r == '0) begin
          tmo_nxt   = it_r.default_timeout_ms;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_TDIV;
          tneg_nxt  = 1'b0;
          stop_nxt  = 1'b0;
        end
      end

      // timeout: |head - now| / 1000 by reciprocal multiply, sign restored
      ST_TDIV: begin
        m_ra = '0;
        if (!stop_r) begin
          stop_nxt = 1'b1;
          tneg_nxt = head_diff[31];
          tmag_nxt = head_diff[31] ? (~head_diff + 32'd1) : head_diff;
        end else begin
          tmo_nxt   = tneg_r ? -$signed(tquo) : $signed(tquo);
          state_nxt = ST_EMIT;
        end
      end

      // one result per cycle
      ST_EMIT: begin
        out_strobe            = 1'b1;
        out_item.timeout_ms   = tmo_r;
        out_item.queue_count  = (32'(count_r) > 32'd63) ? 6'd63 : 6'(count_r);
        out_item.dropped_full = drop_r;
        if (nsent_r != '0) begin
          out_item.send_valid = 1'b1;
          out_item.sent_tag   = sent_q[emit_r[$clog2(MaxResults)-1:0]];
        end
        if (nsent_r == '0 || emit_r + 1'b1 == nsent_r) begin
          out_item.last = 1'b1;
          state_nxt     = ST_IDLE;
        end
        emit_nxt = emit_r + 1'b1;
      end

      // single direct send: stage it, then compute the timeout
      ST_EMIT_LAST: begin
        sent_we   = 1'b1;
        sent_wd   = it_r.packet_tag;
        nsent_nxt = SentW'(1);
        state_nxt = ST_HEAD_RD;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      bpos_r   <= '0;
      bstart_r <= '0;
      bstep_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      bpos_r   <= bpos_nxt;
      bstart_r <= bstart_nxt;
      bstep_r  <= bstep_nxt;
    end
    it_r       <= it_nxt;
    rd_i_r     <= rd_i_nxt;
    wr_j_r     <= wr_j_nxt;
    ins_done_r <= ins_done_nxt;
    drop_r     <= drop_nxt;
    stop_r     <= stop_nxt;
    new_r      <= new_nxt;
    nsent_r    <= nsent_nxt;
    emit_r     <= emit_nxt;
    tmo_r      <= tmo_nxt;
    tneg_r     <= tneg_nxt;
    tmag_r     <= tmag_nxt;
  end

  // checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(QUEUE_DEPTH)) else $error("queue count overflow");
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy) else $error("result while idle");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.last) |=> !busy) else $error("busy after last");
  a_sent_max: assert property (@(posedge clk) disable iff (!rst_n)
    nsent_r <= SentW'(MaxResults)) else $error("too many sends");

endmodule

>>> sv/psp_ram.sv
module psp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> sv/psp_div.sv
// Restoring divider, one quotient bit per cycle.
module psp_div #(
  parameter int unsigned Width = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [Width-1:0] dividend,
  input  logic [Width-1:0] divisor,
  output logic             done,
  output logic [Width-1:0] quotient
);

  localparam int unsigned CntW = $clog2(Width + 1);

  logic [Width-1:0] q_r, q_nxt;
  logic [Width-1:0] rem_r, rem_nxt;
  logic [Width-1:0] dvs_r, dvs_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [Width:0]   trial;

  // shift in one dividend bit, subtract when it fits
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r, q_r[Width-1]} - {1'b0, dvs_r};
    if (go) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CntW'(Width);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[Width]) begin
        rem_nxt = trial[Width-1:0];
        q_nxt   = {q_r[Width-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[Width-2:0], q_r[Width-1]};
        q_nxt   = {q_r[Width-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = busy_r && (cnt_r == CntW'(1)) && !go;
  assign quotient = q_nxt;

endmodule
